@@ rtl/core/sps_pkg.sv @@
package sps_pkg;

    // fixed table geometry
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int POS_W       = 32;
    localparam int OWNER_W     = 10;

    // request codes
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_SORT   = 2'd3
    } req_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_PASS   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_RSVD  = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_AXIS   = 2'd0;
    localparam logic [1:0] CFG_PAIREN = 2'd1;

    // one table entry
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [OWNER_W-1:0] owner;
        logic               is_max;
    } entry_t;

    // access request from the sequencer to the boundary store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

endpackage

@@ rtl/core/sps_store.sv @@
module sps_store
    import sps_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [STORE_DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sweep_prune_boundary_sorter_unit.sv @@
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------------------------
// s_        | in        | s_tvalid / s_tready | s_tuser req_type; s_tdata request fields
// m_        | out       | m_tvalid / m_tready | m_tuser kind; m_tdata result fields; m_tlast
// cfg_      | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// in a sort step one entry is read, compared and written back per cycle while the output
// register is free to take each result beat
// one request of any kind (add, update, remove or sort step) is worked on at a time
// aresetn (synchronous) empties the table and sets the sort cursor to one; no clearing pass
// a stalled result beat holds the sequencer; a new request beat is taken while the last
// result beat of the previous request still waits in the output register
module sweep_prune_boundary_sorter_unit
    import sps_pkg::*;
#(
    parameter int MAX_OBJECTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [55:0] s_tdata,   // owner_id, is_max, position, slot_index, zero pad

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // kind
    output logic [31:0] m_tdata,   // status, new_index, moved_owner, pair_event,
                                   // other_owner, overlap_begin, axis_out
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam int CAPACITY = (2 * MAX_OBJECTS < STORE_DEPTH) ? 2 * MAX_OBJECTS : STORE_DEPTH;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_UPD    = 7'b0000100,
        S_RMREAD = 7'b0001000,
        S_LOADE  = 7'b0010000,
        S_CMP    = 7'b0100000,
        S_FINAL  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [OWNER_W-1:0]  owner_reg, owner_next;
    logic                is_max_reg, is_max_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  cursor_reg, cursor_next;
    logic [ADDR_W-1:0]   dst_reg, dst_next;
    entry_t              e_reg, e_next;
    logic [1:0]          axis_reg;
    logic                pair_en_reg;

    logic                m_valid_reg;
    logic [1:0]          m_kind_reg;
    logic [31:0]         m_data_reg;
    logic                m_last_reg;

    mem_req_t            mreq;
    entry_t              rd_data;

    // result beat under construction
    logic                emit;
    kind_t               r_kind;
    status_t             r_status;
    logic [ADDR_W-1:0]   r_idx;
    logic [OWNER_W-1:0]  r_moved;
    logic                r_pe;
    logic [OWNER_W-1:0]  r_other;
    logic                r_ob;
    logic [1:0]          r_axis;
    logic                r_last;

    logic                out_free;
    logic                slot_bad;
    logic [COUNT_W-1:0]  last_ix;

    sps_store u_store (
        .aclk    (aclk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign slot_bad  = ({1'b0, slot_reg} >= count_reg);
    assign last_ix   = count_reg - COUNT_W'(1);

    // request sequencer
    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        owner_next  = owner_reg;
        is_max_next = is_max_reg;
        pos_next    = pos_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        dst_next    = dst_reg;
        e_next      = e_reg;
        mreq        = '0;
        emit        = 1'b0;
        r_kind      = KIND_ACK;
        r_status    = STAT_OK;
        r_idx       = '0;
        r_moved     = '0;
        r_pe        = 1'b0;
        r_other     = '0;
        r_ob        = 1'b0;
        r_axis      = '0;
        r_last      = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next    = req_t'(s_tuser);
                    owner_next  = s_tdata[9:0];
                    is_max_next = s_tdata[10];
                    pos_next    = s_tdata[42:11];
                    slot_next   = s_tdata[48:43];
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                unique case (req_reg)
                    REQ_ADD: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg >= CAP_C) begin
                                r_kind   = KIND_ERROR;
                                r_status = STAT_FULL;
                            end else begin
                                mreq.wr_en   = 1'b1;
                                mreq.wr_addr = count_reg[ADDR_W-1:0];
                                mreq.wr_data = '{pos: pos_reg, owner: owner_reg,
                                                 is_max: is_max_reg};
                                r_idx        = count_reg[ADDR_W-1:0];
                                count_next   = count_reg + COUNT_W'(1);
                            end
                        end
                    end
                    REQ_UPDATE: begin
                        if (slot_bad) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                r_kind     = KIND_ERROR;
                                r_status   = STAT_RANGE;
                                state_next = S_IDLE;
                            end
                        end else begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = slot_reg;
                            state_next   = S_UPD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (slot_bad) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                r_kind     = KIND_ERROR;
                                r_status   = STAT_RANGE;
                                state_next = S_IDLE;
                            end
                        end else if ({1'b0, slot_reg} < last_ix) begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = last_ix[ADDR_W-1:0];
                            state_next   = S_RMREAD;
                        end else if (out_free) begin
                            // removing the last entry only shrinks the table
                            emit       = 1'b1;
                            r_idx      = slot_reg;
                            count_next = last_ix;
                            state_next = S_IDLE;
                        end
                    end
                    REQ_SORT: begin
                        if (cursor_reg >= count_reg || cursor_reg[COUNT_W-1]) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                r_kind      = KIND_PASS;
                                r_axis      = axis_reg;
                                cursor_next = COUNT_W'(1);
                                state_next  = S_IDLE;
                            end
                        end else begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = cursor_reg[ADDR_W-1:0];
                            state_next   = S_LOADE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // position write back keeping owner and mark
            S_UPD: begin
                if (out_free) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = slot_reg;
                    mreq.wr_data = '{pos: pos_reg, owner: rd_data.owner,
                                     is_max: rd_data.is_max};
                    emit         = 1'b1;
                    r_idx        = slot_reg;
                    state_next   = S_IDLE;
                end
            end

            // last entry moves into the freed slot
            S_RMREAD: begin
                if (out_free) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = slot_reg;
                    mreq.wr_data = rd_data;
                    emit         = 1'b1;
                    r_kind       = KIND_MOVE;
                    r_idx        = slot_reg;
                    r_moved      = rd_data.owner;
                    count_next   = last_ix;
                    state_next   = S_IDLE;
                end
            end

            // element to insert is in hand, fetch its lower neighbor
            S_LOADE: begin
                e_next       = rd_data;
                dst_next     = cursor_reg[ADDR_W-1:0];
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = cursor_reg[ADDR_W-1:0] - ADDR_W'(1);
                state_next   = S_CMP;
            end

            // one shift per cycle while the neighbor lies strictly above and the output register is free
            S_CMP: begin
                if ($signed(rd_data.pos) > $signed(e_reg.pos)) begin
                    if (out_free) begin
                        mreq.wr_en   = 1'b1;
                        mreq.wr_addr = dst_reg;
                        mreq.wr_data = rd_data;
                        emit         = 1'b1;
                        r_kind       = KIND_MOVE;
                        r_idx        = dst_reg;
                        r_moved      = rd_data.owner;
                        r_last       = 1'b0;
                        if (pair_en_reg && (e_reg.is_max != rd_data.is_max)) begin
                            r_pe    = 1'b1;
                            r_other = e_reg.owner;
                            r_ob    = !e_reg.is_max;
                        end
                        dst_next = dst_reg - ADDR_W'(1);
                        if (dst_reg != ADDR_W'(1)) begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = dst_reg - ADDR_W'(2);
                        end else begin
                            state_next = S_FINAL;
                        end
                    end
                end else begin
                    state_next = S_FINAL;
                end
            end

            // drop the element into its place
            S_FINAL: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (dst_reg != cursor_reg[ADDR_W-1:0]) begin
                        mreq.wr_en   = 1'b1;
                        mreq.wr_addr = dst_reg;
                        mreq.wr_data = e_reg;
                        r_kind       = KIND_MOVE;
                        r_idx        = dst_reg;
                        r_moved      = e_reg.owner;
                    end else begin
                        r_idx = cursor_reg[ADDR_W-1:0];
                    end
                    cursor_next = cursor_reg + COUNT_W'(1);
                    state_next  = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cursor_reg  <= COUNT_W'(1);
            axis_reg    <= '0;
            pair_en_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_AXIS) begin
                    axis_reg <= cfg_data;
                end else if (cfg_index == CFG_PAIREN) begin
                    pair_en_reg <= cfg_data[0];
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and working payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        owner_reg  <= owner_next;
        is_max_reg <= is_max_next;
        pos_reg    <= pos_next;
        slot_reg   <= slot_next;
        dst_reg    <= dst_next;
        e_reg      <= e_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg <= r_kind;
            m_data_reg <= {r_axis, r_ob, r_other, r_pe, r_moved, r_idx, r_status};
            m_last_reg <= r_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_cursor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg != '0)
        else $error("sort cursor reached zero");

    a_pass_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_PASS || m_tuser == KIND_ERROR)) |-> m_tlast)
        else $error("pass-done or error beat not last");

    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.wr_en |-> (state_reg != S_IDLE && out_free))
        else $error("store written without a result slot");
`endif

endmodule
